// ===== design/adm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive damping admittance package
// Shared constants, register indexes, state types and transaction structs.
// ----------------------------------------------------------------------------
package adm_pkg;

   localparam int NAX = 6;
   localparam int AXES = 6;
   localparam int MUL_W = 40;
   localparam int ACC_W = 58;
   localparam int DIVN_W = 74;
   localparam int DIVD_W = 41;
   localparam int DIVQ_W = 42;
   localparam int DIV_STEPS = 74;

   localparam logic [2:0] REG_PERIOD = 3'd0;
   localparam logic [2:0] REG_RATE = 3'd1;
   localparam logic [2:0] REG_AXIS0 = 3'd2;

   localparam logic [23:0] PERIOD_RESET = 24'd16777;
   localparam logic [15:0] RATE_RESET = 16'd328;
   localparam logic [31:0] MD_RESET_01 = 32'd111411968;
   localparam logic [31:0] MD_RESET_2 = 32'd98304256;
   localparam logic [31:0] MD_RESET_345 = 32'd3277056;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_HOLD
   } top_state_type;

   typedef enum logic [2:0] {
      AX_IDLE,
      AX_MUL_GO,
      AX_MUL_WAIT,
      AX_VDIV_GO,
      AX_VDIV_WAIT,
      AX_PDIV_GO,
      AX_PDIV_WAIT,
      AX_DONE
   } axis_state_type;

   typedef struct packed {
      logic [23:0]        period;
      logic [15:0]        rate;
      logic [15:0]        damping;
      logic [15:0]        mass;
      logic signed [24:0] err;
      logic signed [31:0] dv_prev;
      logic signed [31:0] phi_prev;
      logic signed [24:0] err_prev;
   } axis_in_type;

   typedef struct packed {
      logic signed [31:0] dv;
      logic signed [31:0] phi;
   } axis_out_type;

endpackage

`default_nettype wire

// ===== design/adm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive damping admittance channels
// Request, response and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface adm_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] actual_force_0;
   logic signed [23:0] actual_force_1;
   logic signed [23:0] actual_force_2;
   logic signed [23:0] actual_force_3;
   logic signed [23:0] actual_force_4;
   logic signed [23:0] actual_force_5;
   logic signed [23:0] target_force_0;
   logic signed [23:0] target_force_1;
   logic signed [23:0] target_force_2;
   logic signed [23:0] target_force_3;
   logic signed [23:0] target_force_4;
   logic signed [23:0] target_force_5;

   modport source (output valid, output actual_force_0, output actual_force_1,
      output actual_force_2, output actual_force_3, output actual_force_4,
      output actual_force_5, output target_force_0, output target_force_1,
      output target_force_2, output target_force_3, output target_force_4,
      output target_force_5, input ready);
   modport sink (input valid, input actual_force_0, input actual_force_1,
      input actual_force_2, input actual_force_3, input actual_force_4,
      input actual_force_5, input target_force_0, input target_force_1,
      input target_force_2, input target_force_3, input target_force_4,
      input target_force_5, output ready);
endinterface

interface adm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] velocity_delta_0;
   logic signed [31:0] velocity_delta_1;
   logic signed [31:0] velocity_delta_2;
   logic signed [31:0] velocity_delta_3;
   logic signed [31:0] velocity_delta_4;
   logic signed [31:0] velocity_delta_5;

   modport source (output valid, output velocity_delta_0, output velocity_delta_1,
      output velocity_delta_2, output velocity_delta_3, output velocity_delta_4,
      output velocity_delta_5, input ready);
   modport sink (input valid, input velocity_delta_0, input velocity_delta_1,
      input velocity_delta_2, input velocity_delta_3, input velocity_delta_4,
      input velocity_delta_5, output ready);
endinterface

interface adm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/adaptive_damping_admittance_step.sv =====
`default_nettype none
// Each axis runs seven serial products and at most two divisions. A sample passes from
// acceptance to response through the serial multiplier and divider that the axes use
// in turn. One sample is in work at a time; the next is taken only once its response
// has been loaded for output.
// Reset (synchronous, active high) restores the default registers and clears the
// per-axis history to zero.
// ----------------------------------------------------------------------------
// Adaptive damping admittance step
// Six-axis admittance controller with adaptive damping compensation.
// ----------------------------------------------------------------------------
module adaptive_damping_admittance_step (
   input  wire logic clock,
   input  wire logic reset,
   adm_req_if.sink   req_chan,
   adm_rsp_if.source rsp_chan,
   adm_csr_if.sink   csr_chan
);

   adm_pkg::top_state_type state_ff, state_in;
   logic [2:0]          axis_ff, axis_in;
   logic                start_ff, start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         period_ff;
   logic [15:0]         rate_ff;
   logic [31:0]         md_ff [adm_pkg::NAX];
   logic signed [31:0]  dvp_ff [adm_pkg::NAX];
   logic signed [31:0]  php_ff [adm_pkg::NAX];
   logic signed [24:0]  ep_ff [adm_pkg::NAX];
   logic signed [24:0]  err_ff [adm_pkg::NAX];
   logic signed [31:0]  vel_ff [adm_pkg::NAX];
   logic signed [31:0]  out_ff [adm_pkg::NAX];
   logic signed [23:0]  act [adm_pkg::NAX];
   logic signed [23:0]  tgt [adm_pkg::NAX];

   logic                   req_fire, load_out, core_done;
   adm_pkg::axis_in_type   core_in;
   adm_pkg::axis_out_type  core_out;

   assign act[0] = req_chan.actual_force_0;
   assign act[1] = req_chan.actual_force_1;
   assign act[2] = req_chan.actual_force_2;
   assign act[3] = req_chan.actual_force_3;
   assign act[4] = req_chan.actual_force_4;
   assign act[5] = req_chan.actual_force_5;
   assign tgt[0] = req_chan.target_force_0;
   assign tgt[1] = req_chan.target_force_1;
   assign tgt[2] = req_chan.target_force_2;
   assign tgt[3] = req_chan.target_force_3;
   assign tgt[4] = req_chan.target_force_4;
   assign tgt[5] = req_chan.target_force_5;

   assign req_chan.ready = (state_ff == adm_pkg::TOP_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign core_in.period = period_ff;
   assign core_in.rate = rate_ff;
   assign core_in.damping = md_ff[axis_ff][31:16];
   assign core_in.mass = md_ff[axis_ff][15:0];
   assign core_in.err = err_ff[axis_ff];
   assign core_in.dv_prev = dvp_ff[axis_ff];
   assign core_in.phi_prev = php_ff[axis_ff];
   assign core_in.err_prev = ep_ff[axis_ff];

   adm_axis u_axis (
      .clock(clock), .reset(reset), .start(start_ff), .in_data(core_in),
      .done(core_done), .result(core_out)
   );

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      start_in = 1'b0;
      load_out = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         adm_pkg::TOP_IDLE: begin
            if (req_fire) begin
               axis_in = '0;
               start_in = 1'b1;
               state_in = adm_pkg::TOP_RUN;
            end
         end
         adm_pkg::TOP_RUN: begin
            if (core_done) begin
               if (axis_ff == 3'(adm_pkg::AXES - 1)) begin
                  if (!rsp_valid_ff || rsp_chan.ready) begin
                     load_out = 1'b1;
                     state_in = adm_pkg::TOP_IDLE;
                  end else begin
                     state_in = adm_pkg::TOP_HOLD;
                  end
               end else begin
                  axis_in = axis_ff + 3'd1;
                  start_in = 1'b1;
               end
            end
         end
         adm_pkg::TOP_HOLD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = adm_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = adm_pkg::TOP_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adm_pkg::TOP_IDLE;
         axis_ff <= '0;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff <= adm_pkg::PERIOD_RESET;
         rate_ff <= adm_pkg::RATE_RESET;
         md_ff[0] <= adm_pkg::MD_RESET_01;
         md_ff[1] <= adm_pkg::MD_RESET_01;
         md_ff[2] <= adm_pkg::MD_RESET_2;
         md_ff[3] <= adm_pkg::MD_RESET_345;
         md_ff[4] <= adm_pkg::MD_RESET_345;
         md_ff[5] <= adm_pkg::MD_RESET_345;
         for (int i = 0; i < adm_pkg::NAX; i++) begin
            dvp_ff[i] <= '0;
            php_ff[i] <= '0;
            ep_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               adm_pkg::REG_PERIOD: period_ff <= csr_chan.data[23:0];
               adm_pkg::REG_RATE: rate_ff <= csr_chan.data[15:0];
               default: begin
                  for (int i = 0; i < adm_pkg::NAX; i++) begin
                     if (csr_chan.index == adm_pkg::REG_AXIS0 + 3'(i)) begin
                        md_ff[i] <= csr_chan.data;
                     end
                  end
               end
            endcase
         end
         if (core_done) begin
            dvp_ff[axis_ff] <= core_out.dv;
            php_ff[axis_ff] <= core_out.phi;
            ep_ff[axis_ff] <= err_ff[axis_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < adm_pkg::NAX; i++) begin
            err_ff[i] <= 25'(act[i]) - 25'(tgt[i]);
         end
      end
      if (core_done) begin
         vel_ff[axis_ff] <= core_out.dv;
      end
      if (load_out) begin
         for (int i = 0; i < adm_pkg::NAX; i++) begin
            if (i >= adm_pkg::AXES) begin
               out_ff[i] <= '0;
            end else if (core_done && axis_ff == 3'(i)) begin
               out_ff[i] <= core_out.dv;
            end else begin
               out_ff[i] <= vel_ff[i];
            end
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.velocity_delta_0 = out_ff[0];
   assign rsp_chan.velocity_delta_1 = out_ff[1];
   assign rsp_chan.velocity_delta_2 = out_ff[2];
   assign rsp_chan.velocity_delta_3 = out_ff[3];
   assign rsp_chan.velocity_delta_4 = out_ff[4];
   assign rsp_chan.velocity_delta_5 = out_ff[5];

`ifndef NO_ASSERTIONS
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == adm_pkg::TOP_RUN ||
                               $past(state_ff) == adm_pkg::TOP_HOLD))
      else $error("response raised outside a computation");
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == adm_pkg::TOP_RUN |-> axis_ff < 3'(adm_pkg::AXES))
      else $error("axis counter out of range");
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      core_done |-> state_ff == adm_pkg::TOP_RUN)
      else $error("axis result outside a computation");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == adm_pkg::TOP_RUN && start_ff && axis_ff == '0)
      else $error("accepted transaction did not start axis zero");
`endif

endmodule

`default_nettype wire

// ===== design/adm_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiplier retiring one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module adm_mul (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [adm_pkg::MUL_W-1:0] a,
   input  wire logic [adm_pkg::MUL_W-1:0] b,
   output logic                          done,
   output logic [2*adm_pkg::MUL_W-1:0]   p
);

   logic                          busy_ff, busy_in;
   logic [2*adm_pkg::MUL_W-1:0]   a_ff, a_in;
   logic [adm_pkg::MUL_W-1:0]     b_ff, b_in;
   logic [2*adm_pkg::MUL_W-1:0]   p_ff, p_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
   end

   always_comb begin
      busy_in = busy_ff;
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         a_in = {{adm_pkg::MUL_W{1'b0}}, a};
         b_in = b;
         p_in = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            if (b_ff[0]) begin
               p_in = p_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ===== design/adm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring long division taking one dividend bit per cycle.
// ----------------------------------------------------------------------------
module adm_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [adm_pkg::DIVN_W-1:0] dividend,
   input  wire logic [adm_pkg::DIVD_W-1:0] divisor,
   output logic                           done,
   output logic [adm_pkg::DIVQ_W-1:0]     quotient
);

   logic                         busy_ff, busy_in;
   logic [6:0]                   cnt_ff, cnt_in;
   logic [adm_pkg::DIVN_W-1:0]   n_ff, n_in;
   logic [adm_pkg::DIVD_W-1:0]   d_ff, d_in;
   logic [adm_pkg::DIVD_W-1:0]   rem_ff, rem_in;
   logic [adm_pkg::DIVQ_W-1:0]   q_ff, q_in;
   logic [adm_pkg::DIVD_W:0]     trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      done = 1'b0;
      trial = {rem_ff, n_ff[adm_pkg::DIVN_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 7'(adm_pkg::DIV_STEPS);
         n_in = dividend;
         d_in = divisor;
         rem_in = '0;
         q_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            cnt_in = cnt_ff - 7'd1;
            n_in = n_ff << 1;
            if (trial >= {1'b0, d_ff}) begin
               rem_in = adm_pkg::DIVD_W'(trial - {1'b0, d_ff});
               q_in = {q_ff[adm_pkg::DIVQ_W-2:0], 1'b1};
            end else begin
               rem_in = trial[adm_pkg::DIVD_W-1:0];
               q_in = {q_ff[adm_pkg::DIVQ_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quotient = q_ff;

endmodule

`default_nettype wire

// ===== design/adm_axis.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Axis sequencer
// Steps one axis update through the serial multiplier and divider.
// ----------------------------------------------------------------------------
module adm_axis (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire adm_pkg::axis_in_type in_data,
   output logic                      done,
   output adm_pkg::axis_out_type     result
);

   adm_pkg::axis_state_type state_ff, state_in;
   logic [2:0]                           step_ff, step_in;
   logic signed [adm_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [adm_pkg::MUL_W-1:0]            bt_ff, bt_in;
   logic [adm_pkg::MUL_W-1:0]            st_ff, st_in;
   logic [adm_pkg::MUL_W-1:0]            x_ff, x_in;
   logic signed [31:0]                   dv_ff, dv_in;
   logic signed [31:0]                   phi_ff, phi_in;

   logic                        mul_start, mul_done;
   logic [adm_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic [2*adm_pkg::MUL_W-1:0] mul_p;
   logic                        div_start, div_done;
   logic [adm_pkg::DIVN_W-1:0]  div_n;
   logic [adm_pkg::DIVD_W-1:0]  div_d;
   logic [adm_pkg::DIVQ_W-1:0]  div_q;

   logic                        e_neg, dvp_neg, php_neg, ep_neg, term_neg;
   logic [24:0]                 e_mag, ep_mag;
   logic [31:0]                 dvp_mag, php_mag;
   logic [adm_pkg::ACC_W-1:0]   r16, term, nm;
   logic [adm_pkg::DIVD_W-1:0]  den;
   logic                        sat;
   logic [32:0]                 qv;
   logic signed [31:0]          dv_div;
   logic [42:0]                 inc_sum;
   logic [43:0]                 inc;
   logic signed [43:0]          phi_diff;
   logic signed [31:0]          phi_div;

   adm_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .p(mul_p)
   );

   adm_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adm_pkg::AX_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      bt_ff <= bt_in;
      st_ff <= st_in;
      x_ff <= x_in;
      dv_ff <= dv_in;
      phi_ff <= phi_in;
   end

   always_comb begin
      e_neg = in_data.err[24];
      e_mag = e_neg ? 25'(-in_data.err) : 25'(in_data.err);
      ep_neg = in_data.err_prev[24];
      ep_mag = ep_neg ? 25'(-in_data.err_prev) : 25'(in_data.err_prev);
      dvp_neg = in_data.dv_prev[31];
      dvp_mag = dvp_neg ? 32'(-in_data.dv_prev) : 32'(in_data.dv_prev);
      php_neg = in_data.phi_prev[31];
      php_mag = php_neg ? 32'(-in_data.phi_prev) : 32'(in_data.phi_prev);

      case (step_ff)
         3'd0: begin
            mul_a = 40'(in_data.period);
            mul_b = 40'(e_mag);
         end
         3'd1: begin
            mul_a = 40'(in_data.mass);
            mul_b = 40'(dvp_mag);
         end
         3'd2: begin
            mul_a = 40'(in_data.damping);
            mul_b = 40'(in_data.period);
         end
         3'd3: begin
            mul_a = bt_ff;
            mul_b = 40'(php_mag);
         end
         3'd4: begin
            mul_a = 40'(in_data.rate);
            mul_b = 40'(in_data.period);
         end
         3'd5: begin
            mul_a = st_ff;
            mul_b = 40'(ep_mag);
         end
         default: begin
            mul_a = 40'(in_data.rate);
            mul_b = 40'(ep_mag);
         end
      endcase

      r16 = 58'((mul_p + 80'h8000) >> 16);
      case (step_ff)
         3'd0: term_neg = e_neg;
         3'd1: term_neg = dvp_neg;
         3'd3: term_neg = !php_neg;
         default: term_neg = ep_neg;
      endcase
      term = (step_ff == 3'd3 || step_ff == 3'd5) ? r16 : mul_p[adm_pkg::ACC_W-1:0];

      den = {9'd0, in_data.mass, 16'd0} + {1'b0, bt_ff};
      nm = acc_ff[adm_pkg::ACC_W-1] ? 58'(-acc_ff) : 58'(acc_ff);
      sat = nm >= {2'b00, den[40:0], 15'd0};

      qv = ({1'b0, div_q[31:0]} + 33'd1) >> 1;
      if (acc_ff[adm_pkg::ACC_W-1]) begin
         dv_div = qv[31] ? adm_pkg::VAL_MIN : 32'(-qv[31:0]);
      end else begin
         dv_div = qv[31] ? adm_pkg::VAL_MAX : qv[31:0];
      end

      inc_sum = {1'b0, div_q} + 43'd1;
      inc = {2'b00, inc_sum[42:1]};
      phi_diff = 44'(in_data.phi_prev) + (ep_neg ? inc : 44'(-inc));
      if (phi_diff > 44'(adm_pkg::VAL_MAX)) begin
         phi_div = adm_pkg::VAL_MAX;
      end else if (phi_diff < 44'(adm_pkg::VAL_MIN)) begin
         phi_div = adm_pkg::VAL_MIN;
      end else begin
         phi_div = phi_diff[31:0];
      end

      if (state_ff == adm_pkg::AX_PDIV_GO) begin
         div_n = {33'd0, x_ff, 1'b0};
         div_d = {25'd0, in_data.damping};
      end else begin
         div_n = {nm[56:0], 17'd0};
         div_d = den;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      bt_in = bt_ff;
      st_in = st_ff;
      x_in = x_ff;
      dv_in = dv_ff;
      phi_in = phi_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      done = 1'b0;
      case (state_ff)
         adm_pkg::AX_IDLE: begin
            if (start) begin
               step_in = '0;
               acc_in = '0;
               state_in = adm_pkg::AX_MUL_GO;
            end
         end
         adm_pkg::AX_MUL_GO: begin
            mul_start = 1'b1;
            state_in = adm_pkg::AX_MUL_WAIT;
         end
         adm_pkg::AX_MUL_WAIT: begin
            if (mul_done) begin
               case (step_ff)
                  3'd2: bt_in = mul_p[adm_pkg::MUL_W-1:0];
                  3'd4: st_in = mul_p[adm_pkg::MUL_W-1:0];
                  3'd6: x_in = mul_p[adm_pkg::MUL_W-1:0];
                  default: acc_in = acc_ff + (term_neg ? 58'(-term) : term);
               endcase
               step_in = step_ff + 3'd1;
               state_in = (step_ff == 3'd6) ? adm_pkg::AX_VDIV_GO : adm_pkg::AX_MUL_GO;
            end
         end
         adm_pkg::AX_VDIV_GO: begin
            if (den == '0) begin
               dv_in = '0;
               state_in = adm_pkg::AX_PDIV_GO;
            end else if (sat) begin
               dv_in = acc_ff[adm_pkg::ACC_W-1] ? adm_pkg::VAL_MIN : adm_pkg::VAL_MAX;
               state_in = adm_pkg::AX_PDIV_GO;
            end else begin
               div_start = 1'b1;
               state_in = adm_pkg::AX_VDIV_WAIT;
            end
         end
         adm_pkg::AX_VDIV_WAIT: begin
            if (div_done) begin
               dv_in = dv_div;
               state_in = adm_pkg::AX_PDIV_GO;
            end
         end
         adm_pkg::AX_PDIV_GO: begin
            if (in_data.damping == '0) begin
               phi_in = in_data.phi_prev;
               state_in = adm_pkg::AX_DONE;
            end else begin
               div_start = 1'b1;
               state_in = adm_pkg::AX_PDIV_WAIT;
            end
         end
         adm_pkg::AX_PDIV_WAIT: begin
            if (div_done) begin
               phi_in = phi_div;
               state_in = adm_pkg::AX_DONE;
            end
         end
         adm_pkg::AX_DONE: begin
            done = 1'b1;
            state_in = adm_pkg::AX_IDLE;
         end
         default: begin
            state_in = adm_pkg::AX_IDLE;
         end
      endcase
   end

   assign result.dv = dv_ff;
   assign result.phi = phi_ff;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Admittance step testbench
// Drives force samples through the six-axis admittance step under several
// register settings and with random idling on both channels. Every response
// is compared, axis by axis, with given values or with an in-bench fixed-point
// predictor of the velocity, adaptation and error history.
// ----------------------------------------------------------------------------
module testbench;

   localparam longint CYCLE_LIMIT = 40000000;
   localparam int PHASE_ITEMS = 250;
   localparam int PHASES = 6;
   localparam int HOLD_CYCLES = 6000;

   typedef logic signed [23:0] force_vec_type [adm_pkg::NAX];
   typedef struct {
      logic signed [31:0] vel [adm_pkg::NAX];
   } vel_set_type;
   typedef struct {
      logic signed [23:0] act [adm_pkg::NAX];
      logic signed [23:0] tgt [adm_pkg::NAX];
      bit                 typed;
      logic signed [31:0] vel [adm_pkg::NAX];
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   adm_req_if req_chan ();
   adm_rsp_if rsp_chan ();
   adm_csr_if csr_chan ();

   adaptive_damping_admittance_step i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always #5 clock = ~clock;

   logic [23:0] period_reg;
   logic [15:0] rate_reg;
   logic [31:0] md_reg [adm_pkg::NAX];
   longint      dv_hist [adm_pkg::NAX];
   longint      phi_hist [adm_pkg::NAX];
   longint      err_hist [adm_pkg::NAX];

   vel_set_type velocity_queue [$];
   int       fail_count = 0;
   int       resp_count = 0;
   longint   cycle_count = 0;
   int       sender_idle = 0;
   int       receiver_idle = 0;
   bit       hold_request = 1'b0;
   bit       hold_taken = 1'b0;
   int       hold_left = 0;

   function automatic longint unsigned mag_of(longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   function automatic longint apply_sign(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned round_mul16(longint unsigned a, longint unsigned b);
      longint unsigned hi;
      longint unsigned lo;
      hi = b >> 16;
      lo = b & 64'hFFFF;
      return a * hi + ((a * lo + 64'h8000) >> 16);
   endfunction

   function automatic logic signed [31:0] step_axis(int a, longint e);
      longint unsigned t;
      longint unsigned sg;
      longint unsigned m;
      longint unsigned b;
      longint unsigned den;
      longint unsigned nm;
      longint unsigned q1;
      longint unsigned r1;
      longint unsigned q;
      longint unsigned inc;
      longint num;
      longint dv;
      longint phi;
      t = period_reg;
      sg = rate_reg;
      m = md_reg[a][15:0];
      b = md_reg[a][31:16];
      den = (m << 16) + b * t;
      dv = 0;
      num = longint'(t) * e + longint'(m) * dv_hist[a];
      num -= apply_sign(round_mul16(t * b, mag_of(phi_hist[a])), phi_hist[a] < 0);
      num += apply_sign(round_mul16(sg * t, mag_of(err_hist[a])), err_hist[a] < 0);
      if (den != 0) begin
         nm = mag_of(num);
         q1 = nm / den;
         r1 = nm % den;
         if (q1 >= 64'h8000) begin
            q = 64'h8000_0000;
         end else begin
            q = (q1 << 16) + ((r1 << 17) + den) / (den * 2);
         end
         if (num < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            dv = -longint'(q);
         end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            dv = longint'(q);
         end
      end
      if (b != 0) begin
         inc = (2 * sg * mag_of(err_hist[a]) + b) / (2 * b);
         phi = phi_hist[a] - apply_sign(inc, err_hist[a] < 0);
         if (phi > 64'sh7FFF_FFFF) phi = 64'sh7FFF_FFFF;
         if (phi < -64'sh8000_0000) phi = -64'sh8000_0000;
         phi_hist[a] = phi;
      end
      dv_hist[a] = dv;
      err_hist[a] = e;
      return dv[31:0];
   endfunction

   function automatic vel_set_type predict_velocity(force_vec_type act, force_vec_type tgt);
      vel_set_type r;
      for (int a = 0; a < adm_pkg::NAX; a++) begin
         r.vel[a] = (a < adm_pkg::AXES) ?
            step_axis(a, longint'(act[a]) - longint'(tgt[a])) : '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      vel_set_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         resp_count <= resp_count + 1;
         if (velocity_queue.size() == 0) begin
            $error("Response transaction arrived with no sample outstanding");
            fail_count++;
         end else begin
            want = velocity_queue.pop_front();
            if (rsp_chan.velocity_delta_0 !== want.vel[0]) begin
               $error("velocity_delta_0: expected %0d, got %0d", want.vel[0],
                  rsp_chan.velocity_delta_0);
               fail_count++;
            end
            if (rsp_chan.velocity_delta_1 !== want.vel[1]) begin
               $error("velocity_delta_1: expected %0d, got %0d", want.vel[1],
                  rsp_chan.velocity_delta_1);
               fail_count++;
            end
            if (rsp_chan.velocity_delta_2 !== want.vel[2]) begin
               $error("velocity_delta_2: expected %0d, got %0d", want.vel[2],
                  rsp_chan.velocity_delta_2);
               fail_count++;
            end
            if (rsp_chan.velocity_delta_3 !== want.vel[3]) begin
               $error("velocity_delta_3: expected %0d, got %0d", want.vel[3],
                  rsp_chan.velocity_delta_3);
               fail_count++;
            end
            if (rsp_chan.velocity_delta_4 !== want.vel[4]) begin
               $error("velocity_delta_4: expected %0d, got %0d", want.vel[4],
                  rsp_chan.velocity_delta_4);
               fail_count++;
            end
            if (rsp_chan.velocity_delta_5 !== want.vel[5]) begin
               $error("velocity_delta_5: expected %0d, got %0d", want.vel[5],
                  rsp_chan.velocity_delta_5);
               fail_count++;
            end
         end
      end
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle);
      end
   end

   task automatic write_register(logic [2:0] index, logic [31:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      case (index)
         adm_pkg::REG_PERIOD: period_reg = data[23:0];
         adm_pkg::REG_RATE:   rate_reg = data[15:0];
         default:             md_reg[index - adm_pkg::REG_AXIS0] = data;
      endcase
   endtask

   task automatic send_sample(force_vec_type act, force_vec_type tgt, bit typed,
         logic signed [31:0] typed_vel [adm_pkg::NAX]);
      vel_set_type want;
      while ($urandom_range(99) < sender_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.actual_force_0 <= act[0];
      req_chan.actual_force_1 <= act[1];
      req_chan.actual_force_2 <= act[2];
      req_chan.actual_force_3 <= act[3];
      req_chan.actual_force_4 <= act[4];
      req_chan.actual_force_5 <= act[5];
      req_chan.target_force_0 <= tgt[0];
      req_chan.target_force_1 <= tgt[1];
      req_chan.target_force_2 <= tgt[2];
      req_chan.target_force_3 <= tgt[3];
      req_chan.target_force_4 <= tgt[4];
      req_chan.target_force_5 <= tgt[5];
      do @(posedge clock); while (!req_chan.ready);
      want = predict_velocity(act, tgt);
      if (typed) begin
         want.vel = typed_vel;
      end
      velocity_queue.push_back(want);
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (velocity_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [23:0] random_force(bit full_range);
      if (full_range) return 24'($urandom);
      return $signed(24'($urandom_range(4095))) - 24'sd2048;
   endfunction

   sample_row_type directed_rows [$];

   function automatic void add_row(int act_val, int tgt_val, bit typed, int vel_val);
      sample_row_type row;
      for (int a = 0; a < adm_pkg::NAX; a++) begin
         row.act[a] = 24'(act_val);
         row.tgt[a] = 24'(tgt_val);
         row.vel[a] = vel_val;
      end
      row.typed = typed;
      directed_rows.push_back(row);
   endfunction

   initial begin
      force_vec_type act;
      force_vec_type tgt;
      logic signed [31:0] none_vel [adm_pkg::NAX];
      req_chan.valid = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      req_chan.actual_force_0 = '0;
      req_chan.actual_force_1 = '0;
      req_chan.actual_force_2 = '0;
      req_chan.actual_force_3 = '0;
      req_chan.actual_force_4 = '0;
      req_chan.actual_force_5 = '0;
      req_chan.target_force_0 = '0;
      req_chan.target_force_1 = '0;
      req_chan.target_force_2 = '0;
      req_chan.target_force_3 = '0;
      req_chan.target_force_4 = '0;
      req_chan.target_force_5 = '0;
      period_reg = adm_pkg::PERIOD_RESET;
      rate_reg = adm_pkg::RATE_RESET;
      md_reg[0] = adm_pkg::MD_RESET_01;
      md_reg[1] = adm_pkg::MD_RESET_01;
      md_reg[2] = adm_pkg::MD_RESET_2;
      md_reg[3] = adm_pkg::MD_RESET_345;
      md_reg[4] = adm_pkg::MD_RESET_345;
      md_reg[5] = adm_pkg::MD_RESET_345;
      for (int a = 0; a < adm_pkg::NAX; a++) begin
         dv_hist[a] = 0;
         phi_hist[a] = 0;
         err_hist[a] = 0;
         none_vel[a] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // With zero history and zero error the first response is exactly zero.
      add_row(0, 0, 1'b1, 0);
      add_row(0, 0, 1'b1, 0);
      add_row(8388607, -8388608, 1'b0, 0);
      add_row(-8388608, 8388607, 1'b0, 0);
      add_row(8388607, 8388607, 1'b0, 0);
      add_row(-8388608, -8388608, 1'b0, 0);
      add_row(1, 0, 1'b0, 0);
      add_row(0, 1, 1'b0, 0);
      add_row(-1, -8388608, 1'b0, 0);
      add_row(8388607, 0, 1'b0, 0);
      add_row(8388607, 0, 1'b0, 0);
      add_row(0, 0, 1'b0, 0);
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].act, directed_rows[i].tgt, directed_rows[i].typed,
            directed_rows[i].vel);
      end
      drain_responses();

      for (int p = 0; p < PHASES; p++) begin
         case (p % 3)
            0: begin sender_idle = 7;  receiver_idle = 87; end
            1: begin sender_idle = 87; receiver_idle = 7;  end
            default: begin sender_idle = 0; receiver_idle = 0; end
         endcase
         case (p)
            0: ;
            1: begin
               write_register(adm_pkg::REG_PERIOD, 32'd1);
               write_register(adm_pkg::REG_RATE, 32'd0);
               for (int a = 0; a < adm_pkg::NAX; a++) begin
                  write_register(adm_pkg::REG_AXIS0 + 3'(a), 32'd65537);
               end
            end
            2: begin
               write_register(adm_pkg::REG_PERIOD, 32'hFFFF_FFFF);
               write_register(adm_pkg::REG_RATE, 32'hFFFF_FFFF);
               for (int a = 0; a < adm_pkg::NAX; a++) begin
                  write_register(adm_pkg::REG_AXIS0 + 3'(a), 32'hFFFF_FFFF);
               end
            end
            3: begin
               // Massless axes leave only the damping term in the denominator.
               write_register(adm_pkg::REG_PERIOD, $urandom_range(20000, 1));
               write_register(adm_pkg::REG_RATE, $urandom_range(65535));
               for (int a = 0; a < adm_pkg::NAX; a++) begin
                  write_register(adm_pkg::REG_AXIS0 + 3'(a),
                     {16'($urandom_range(65535, 1)), 16'd0});
               end
            end
            default: begin
               write_register(adm_pkg::REG_PERIOD, $urandom_range(16777215, 1));
               write_register(adm_pkg::REG_RATE, $urandom_range(65535));
               for (int a = 0; a < adm_pkg::NAX; a++) begin
                  write_register(adm_pkg::REG_AXIS0 + 3'(a), {16'($urandom_range(65535, 1)),
                     16'($urandom_range(65535))});
               end
            end
         endcase
         if (p == 1) begin
            hold_request <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            for (int a = 0; a < adm_pkg::NAX; a++) begin
               act[a] = random_force($urandom_range(3) == 0);
               tgt[a] = random_force($urandom_range(3) == 0);
            end
            send_sample(act, tgt, 1'b0, none_vel);
         end
         drain_responses();
      end

      repeat (100) @(posedge clock);
      $display("Checked %0d responses over %0d register settings with idling on both sides.",
         resp_count, PHASES);
      if (fail_count == 0 && velocity_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
